[rtl/qte_pkg.sv]
// Shared widths, types, constants and helper functions of the quaternion to Euler block.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

    // Number of CORDIC vectoring cells in each angle chain (8 to 32).
    localparam int CORDIC_STAGES = 16;

    localparam int QW    = 32;  // quaternion component width, Q2.30
    localparam int PW    = 34;  // width of one Q.30 product
    localparam int SW    = 36;  // width of the sums of products
    localparam int XW    = 38;  // CORDIC vector width, leaves room for the gain
    localparam int ZW    = 35;  // CORDIC angle width, radians in Q.30
    localparam int SQ_N  = 31;  // one result bit of the square root per cell
    localparam int SQ_W  = 62;  // square root remainder and root width
    localparam int MW    = 49;  // width of the scaled angle product
    localparam int IW    = 5;   // CORDIC cell index width

    localparam logic signed [SW-1:0] ONE_Q30   = SW'(64'sd1073741824);
    localparam logic signed [SW-1:0] M_ONE_Q30 = -SW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] PI_Q30    = ZW'(64'sd3373259426);
    localparam logic signed [14:0]   CDEG_PER_RAD = 15'sd5730;
    localparam logic signed [MW-1:0] ROUND_HALF = MW'(64'sd536870912);

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } qte_sq_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } qte_cv_t;

    // atan(2^-i) in Q.30, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q30(input logic [IW-1:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = ZW'(64'sd843314857);
                5'd1:  r = ZW'(64'sd497837829);
                5'd2:  r = ZW'(64'sd263043837);
                5'd3:  r = ZW'(64'sd133525159);
                5'd4:  r = ZW'(64'sd67021687);
                5'd5:  r = ZW'(64'sd33543516);
                5'd6:  r = ZW'(64'sd16775851);
                5'd7:  r = ZW'(64'sd8388437);
                5'd8:  r = ZW'(64'sd4194283);
                5'd9:  r = ZW'(64'sd2097149);
                5'd10: r = ZW'(64'sd1048576);
                5'd11: r = ZW'(64'sd524288);
                5'd12: r = ZW'(64'sd262144);
                5'd13: r = ZW'(64'sd131072);
                5'd14: r = ZW'(64'sd65536);
                5'd15: r = ZW'(64'sd32768);
                5'd16: r = ZW'(64'sd16384);
                5'd17: r = ZW'(64'sd8192);
                5'd18: r = ZW'(64'sd4096);
                5'd19: r = ZW'(64'sd2048);
                5'd20: r = ZW'(64'sd1024);
                5'd21: r = ZW'(64'sd512);
                5'd22: r = ZW'(64'sd256);
                5'd23: r = ZW'(64'sd128);
                5'd24: r = ZW'(64'sd64);
                5'd25: r = ZW'(64'sd32);
                5'd26: r = ZW'(64'sd16);
                5'd27: r = ZW'(64'sd8);
                5'd28: r = ZW'(64'sd4);
                5'd29: r = ZW'(64'sd2);
                5'd30: r = ZW'(64'sd1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Product of two Q2.30 words, floored back to Q.30.
    function automatic logic signed [PW-1:0] mul_q30(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        begin
            p = a * b;
            return p[2*QW-1:30];
        end
    endfunction

    // Folds the vector into the right half plane and sets the starting angle.
    function automatic qte_cv_t cordic_init(input logic signed [XW-1:0] y,
                                            input logic signed [XW-1:0] x);
        qte_cv_t r;
        begin
            r.zero = (x == '0) && (y == '0);
            if (x < 0) begin
                r.x = -x;
                r.y = -y;
                r.z = (y >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                r.x = x;
                r.y = y;
                r.z = '0;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/qte_sqrt_cell.sv]
// One cell of the pipelined integer square root: one result bit per cell.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell
    import qte_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    en,
    input  wire logic [5:0] bit_pos,
    input  wire qte_sq_t din,
    output qte_sq_t      dout
);

    qte_sq_t         data_reg;
    qte_sq_t         data_next;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;

    assign bitv  = SQ_W'(1) << bit_pos;
    assign trial = din.root + bitv;

    always_comb begin
        if (din.rem >= trial) begin
            data_next.rem  = din.rem - trial;
            data_next.root = (din.root >> 1) + bitv;
        end else begin
            data_next.rem  = din.rem;
            data_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule
`default_nettype wire

[rtl/qte_cordic_cell.sv]
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell
    import qte_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [IW-1:0] stage,
    input  wire qte_cv_t       din,
    output qte_cv_t            dout
);

    qte_cv_t              data_reg;
    qte_cv_t              data_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = din.y >>> stage;
    assign dy = din.x >>> stage;

    always_comb begin
        data_next.zero = din.zero;
        if (din.y > 0) begin
            data_next.x = din.x + dx;
            data_next.y = din.y - dy;
            data_next.z = din.z + atan_q30(stage);
        end else begin
            data_next.x = din.x - dx;
            data_next.y = din.y + dy;
            data_next.z = din.z - atan_q30(stage);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule
`default_nettype wire

[rtl/quaternion_to_euler_angles.sv]
// Top level: quaternion to pitch, roll and yaw in hundredths of a degree.
//
// The input channel (s_valid/s_ready) takes one unit quaternion per item as
// four signed Q2.30 words and a presence flag. The result channel
// (m_valid/m_ready) returns one item per input item, in order, with pitch,
// roll and yaw in hundredths of a degree and a status bit that is set when
// the item held no quaternion (the angles are then zero).
// The whole block is one pipeline that moves one step per cycle unless it
// stalls: an input register, the Q.30 products, their sums, the squaring
// for the pitch cosine, a chain of 31 square root cells, the CORDIC fold,
// three chains of CORDIC_STAGES vectoring cells, the degree scaling and the
// output register. Throughput is one item per cycle unless it stalls.
// When the receiver holds m_ready low with a result waiting, every stage
// holds and s_ready drops in the same cycle; nothing is lost or repeated.
// A synchronous active-low reset empties the pipeline; no item is in flight
// after it, and the block accepts items from the next cycle on.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [QW-1:0] s_quat_w,
    input  wire logic signed [QW-1:0] s_quat_x,
    input  wire logic signed [QW-1:0] s_quat_y,
    input  wire logic signed [QW-1:0] s_quat_z,
    input  wire logic                 s_quat_present,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [14:0]        m_pitch_cdeg,
    output logic signed [15:0]        m_roll_cdeg,
    output logic signed [15:0]        m_yaw_cdeg,
    output logic                      m_status
);

    // Side data that travels next to the square root chain.
    typedef struct packed {
        logic                 pres;
        logic signed [XW-1:0] s;
        logic signed [SW-1:0] ry;
        logic signed [SW-1:0] rx;
        logic signed [SW-1:0] yy;
        logic signed [SW-1:0] yx;
    } side_t;

    // Every stage advances when the output register is empty or being taken.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Stage 1: input register.
    logic                 v1_reg;
    logic                 pres1_reg;
    logic signed [QW-1:0] w1_reg, x1_reg, y1_reg, z1_reg;

    // Stage 2: the ten Q.30 products.
    logic                 v2_reg;
    logic                 pres2_reg;
    logic signed [PW-1:0] p_wy_reg, p_xz_reg, p_yz_reg, p_wx_reg, p_xx_reg;
    logic signed [PW-1:0] p_yy_reg, p_xy_reg, p_wz_reg, p_ww_reg, p_zz_reg;

    // Stage 3: sums of products and the clamped sine of pitch.
    logic                 v3_reg;
    logic                 pres3_reg;
    logic signed [QW-1:0] s3_reg;
    logic signed [SW-1:0] ry3_reg, rx3_reg, yy3_reg, yx3_reg;
    logic signed [SW-1:0] s_raw;
    logic signed [SW-1:0] s_clamped;

    // Stage 4: radicand 2^60 - s^2 for the cosine of pitch.
    logic                   v4_reg;
    side_t                  side4_reg;
    logic [SQ_W-1:0]        rad4_reg;
    logic signed [2*QW-1:0] s_sq;

    // Square root chain.
    qte_sq_t         sq_chain [0:SQ_N];
    side_t           sd_reg [0:SQ_N-1];
    logic [SQ_N-1:0] sq_v_reg;

    // CORDIC fold stage and chains.
    qte_cv_t                   cv_chain [0:2][0:CORDIC_STAGES];
    qte_cv_t                   fold_reg [0:2];
    logic                      vf_reg;
    logic                      presf_reg;
    logic [CORDIC_STAGES-1:0]  cd_v_reg;
    logic [CORDIC_STAGES-1:0]  cd_pres_reg;
    logic signed [XW-1:0]      pitch_c;

    // Scaling stage.
    logic                 vm_reg;
    logic                 presm_reg;
    logic signed [MW-1:0] prod_reg [0:2];
    logic signed [ZW-1:0] ang [0:2];
    logic signed [MW-1:0] cdeg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            sq_v_reg <= '0;
            vf_reg   <= 1'b0;
            cd_v_reg <= '0;
            vm_reg   <= 1'b0;
            m_valid  <= 1'b0;
        end else if (adv) begin
            v1_reg   <= s_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            sq_v_reg <= {sq_v_reg[SQ_N-2:0], v4_reg};
            vf_reg   <= sq_v_reg[SQ_N-1];
            cd_v_reg <= {cd_v_reg[CORDIC_STAGES-2:0], vf_reg};
            vm_reg   <= cd_v_reg[CORDIC_STAGES-1];
            m_valid  <= vm_reg;
        end
    end

    // Sums of products, each exact; the sine of pitch is clamped to minus one to one.
    assign s_raw = (SW'(p_wy_reg) - SW'(p_xz_reg)) <<< 1;
    always_comb begin
        if (s_raw > ONE_Q30) begin
            s_clamped = ONE_Q30;
        end else if (s_raw < M_ONE_Q30) begin
            s_clamped = M_ONE_Q30;
        end else begin
            s_clamped = s_raw;
        end
    end

    assign s_sq = s3_reg * s3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            w1_reg    <= s_quat_w;
            x1_reg    <= s_quat_x;
            y1_reg    <= s_quat_y;
            z1_reg    <= s_quat_z;
            pres1_reg <= s_quat_present;

            pres2_reg <= pres1_reg;
            p_wy_reg  <= mul_q30(w1_reg, y1_reg);
            p_xz_reg  <= mul_q30(x1_reg, z1_reg);
            p_yz_reg  <= mul_q30(y1_reg, z1_reg);
            p_wx_reg  <= mul_q30(w1_reg, x1_reg);
            p_xx_reg  <= mul_q30(x1_reg, x1_reg);
            p_yy_reg  <= mul_q30(y1_reg, y1_reg);
            p_xy_reg  <= mul_q30(x1_reg, y1_reg);
            p_wz_reg  <= mul_q30(w1_reg, z1_reg);
            p_ww_reg  <= mul_q30(w1_reg, w1_reg);
            p_zz_reg  <= mul_q30(z1_reg, z1_reg);

            pres3_reg <= pres2_reg;
            s3_reg    <= s_clamped[QW-1:0];
            ry3_reg   <= (SW'(p_yz_reg) + SW'(p_wx_reg)) <<< 1;
            rx3_reg   <= ONE_Q30 - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
            yy3_reg   <= (SW'(p_xy_reg) + SW'(p_wz_reg)) <<< 1;
            yx3_reg   <= SW'(p_ww_reg) + SW'(p_xx_reg) - SW'(p_yy_reg) - SW'(p_zz_reg);

            side4_reg.pres <= pres3_reg;
            side4_reg.s    <= XW'(s3_reg);
            side4_reg.ry   <= ry3_reg;
            side4_reg.rx   <= rx3_reg;
            side4_reg.yy   <= yy3_reg;
            side4_reg.yx   <= yx3_reg;
            rad4_reg       <= (SQ_W'(1) << 60) - SQ_W'(s_sq[60:0]);
        end
    end

    // Square root of the radicand, one bit per cell, highest bit first.
    assign sq_chain[0].rem  = rad4_reg;
    assign sq_chain[0].root = '0;

    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .aclk    (aclk),
            .en      (adv),
            .bit_pos (6'(2 * (SQ_N - 1 - i))),
            .din     (sq_chain[i]),
            .dout    (sq_chain[i+1])
        );

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (i == 0) begin
                    sd_reg[i] <= side4_reg;
                end else begin
                    sd_reg[i] <= sd_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Fold each vector into the right half plane before the CORDIC chains.
    assign pitch_c = $signed(XW'(sq_chain[SQ_N].root[30:0]));

    always_ff @(posedge aclk) begin
        if (adv) begin
            presf_reg   <= sd_reg[SQ_N-1].pres;
            fold_reg[0] <= cordic_init(sd_reg[SQ_N-1].s, pitch_c);
            fold_reg[1] <= cordic_init(XW'(sd_reg[SQ_N-1].ry), XW'(sd_reg[SQ_N-1].rx));
            fold_reg[2] <= cordic_init(XW'(sd_reg[SQ_N-1].yy), XW'(sd_reg[SQ_N-1].yx));
            cd_pres_reg <= {cd_pres_reg[CORDIC_STAGES-2:0], presf_reg};
        end
    end

    // Three chains of vectoring cells: pitch, roll and yaw.
    for (genvar a = 0; a < 3; a++) begin : g_angle
        assign cv_chain[a][0] = fold_reg[a];
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
            qte_cordic_cell u_cell (
                .aclk  (aclk),
                .en    (adv),
                .stage (IW'(i)),
                .din   (cv_chain[a][i]),
                .dout  (cv_chain[a][i+1])
            );
        end

        // A zero vector has angle zero.
        assign ang[a]  = cv_chain[a][CORDIC_STAGES].zero ? '0 : cv_chain[a][CORDIC_STAGES].z;
        assign cdeg[a] = (prod_reg[a] + ROUND_HALF) >>> 30;

        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg[a] <= MW'(ang[a]) * MW'(CDEG_PER_RAD);
            end
        end
    end

    // Saturate to the angle range and zero out items without a quaternion.
    always_ff @(posedge aclk) begin
        if (adv) begin
            presm_reg <= cd_pres_reg[CORDIC_STAGES-1];
            m_status  <= !presm_reg;
            if (!presm_reg) begin
                m_pitch_cdeg <= '0;
                m_roll_cdeg  <= '0;
                m_yaw_cdeg   <= '0;
            end else begin
                if (cdeg[0] > MW'(64'sd9001)) begin
                    m_pitch_cdeg <= 15'sd9001;
                end else if (cdeg[0] < -MW'(64'sd9001)) begin
                    m_pitch_cdeg <= -15'sd9001;
                end else begin
                    m_pitch_cdeg <= cdeg[0][14:0];
                end
                if (cdeg[1] > MW'(64'sd18002)) begin
                    m_roll_cdeg <= 16'sd18002;
                end else if (cdeg[1] < -MW'(64'sd18002)) begin
                    m_roll_cdeg <= -16'sd18002;
                end else begin
                    m_roll_cdeg <= cdeg[1][15:0];
                end
                if (cdeg[2] > MW'(64'sd18002)) begin
                    m_yaw_cdeg <= 16'sd18002;
                end else if (cdeg[2] < -MW'(64'sd18002)) begin
                    m_yaw_cdeg <= -16'sd18002;
                end else begin
                    m_yaw_cdeg <= cdeg[2][15:0];
                end
            end
        end
    end

endmodule
`default_nettype wire
